### rtl/bmbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmbc_pkg
// types, constants and arithmetic helpers for the battery monitor block
// ----------------------------------------------------------------------------
package bmbc_pkg;

    // event codes
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_ENTER  = 2'd1,
        OP_EXIT   = 2'd2,
        OP_FORCE  = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [2:0] CFG_LI_ION_CELL       = 3'd0;
    localparam logic [2:0] CFG_CHANGE_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_FORCE_AFTER_READS = 3'd2;
    localparam logic [2:0] CFG_ALWAYS_BOOST      = 3'd3;
    localparam logic [2:0] CFG_UNDERVOLT_BOOST   = 3'd4;
    localparam logic [2:0] CFG_BOOST_PRESENT     = 3'd5;
    localparam logic [2:0] CFG_BATTERY_PRESENT   = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int ADC_W   = 10;
    localparam int MV_W    = 14;
    localparam int LEVEL_W = 7;
    localparam int READS_W = 8;

    // mv = floor(12100 * adc / 1024)
    localparam int          MV_PROD_W    = 24;
    localparam int          MV_SHIFT     = 10;
    localparam logic [13:0] MV_NUMERATOR = 14'd12100;

    localparam logic [13:0] COIN_LOW_MV    = 14'd1800;
    localparam logic [13:0] COIN_HIGH_MV   = 14'd3000;
    localparam logic [13:0] LION_LOW_MV    = 14'd3000;
    localparam logic [13:0] LION_HIGH_MV   = 14'd4200;
    localparam logic [13:0] BOOST_ENTER_MV = 14'd2600;
    localparam logic [13:0] BOOST_LEAVE_MV = 14'd2800;
    localparam logic [6:0]  FULL_LEVEL     = 7'd100;

    // offset into the range stays below 1200, so 11 bits
    // floor(x / 12) == (x * 2731) >> 15 for every x below 1200
    localparam int          OFS_W        = 11;
    localparam int          RECIP_W      = 12;
    localparam int          RECIP_SHIFT  = 15;
    localparam logic [11:0] RECIP_12     = 12'd2731;

    typedef struct packed {
        t_op              operation;
        logic [ADC_W-1:0] adc_sample;
    } t_in_word;

    typedef struct packed {
        logic [MV_W-1:0]    battery_mv;
        logic [LEVEL_W-1:0] battery_level;
        logic               send_level;
        logic               boost_write;
        logic               boost_on;
        logic               low_voltage_mode;
    } t_out_word;

    // word between the conversion stage and the decision stage
    typedef struct packed {
        t_op             operation;
        logic [MV_W-1:0] battery_mv;
    } t_mv_word;

    typedef struct packed {
        logic               li_ion_cell;
        logic [LEVEL_W-1:0] change_threshold;
        logic [READS_W-1:0] force_after_reads;
        logic               always_boost;
        logic               undervolt_boost;
        logic               boost_present;
        logic               battery_present;
    } t_cfg;

    function automatic logic [MV_W-1:0] adc_to_mv(input logic [ADC_W-1:0] adc);
        logic [MV_PROD_W-1:0] prod;
        prod = MV_PROD_W'(adc) * MV_PROD_W'(MV_NUMERATOR);
        return prod[MV_SHIFT +: MV_W];
    endfunction

    // quotient by 12 of an offset below 1200
    function automatic logic [LEVEL_W-1:0] ofs_div12(input logic [OFS_W-1:0] ofs);
        logic [OFS_W+RECIP_W-1:0] prod;
        prod = (OFS_W+RECIP_W)'(ofs) * (OFS_W+RECIP_W)'(RECIP_12);
        return prod[RECIP_SHIFT +: LEVEL_W];
    endfunction

endpackage
`default_nettype wire

### rtl/bmbc_sample_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmbc_sample_stage
// input register and adc to millivolt conversion register
// ----------------------------------------------------------------------------
module bmbc_sample_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  bmbc_pkg::t_in_word  i_word,
    output logic                o_ready,
    output logic                o_valid,
    output bmbc_pkg::t_mv_word  o_word,
    input  wire                 i_ready
);
    import bmbc_pkg::*;

    logic     r_in_valid;
    t_in_word r_in;
    logic     r_mv_valid;
    t_mv_word r_mv;
    t_mv_word n_mv;
    logic     mv_ready;

    assign mv_ready = !r_mv_valid || i_ready;
    assign o_ready  = !r_in_valid || mv_ready;

    always_comb begin
        n_mv.operation  = r_in.operation;
        n_mv.battery_mv = adc_to_mv(r_in.adc_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mv_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (mv_ready) begin
                r_mv_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_word;
        end
        if (mv_ready && r_in_valid) begin
            r_mv <= n_mv;
        end
    end

    assign o_valid = r_mv_valid;
    assign o_word  = r_mv;

endmodule
`default_nettype wire

### rtl/bmbc_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmbc_decide
// level mapping, report and boost decisions, state and result register
// ----------------------------------------------------------------------------
module bmbc_decide (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bmbc_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    input  bmbc_pkg::t_mv_word  i_word,
    output logic                o_ready,
    output logic                o_valid,
    output bmbc_pkg::t_out_word o_word,
    input  wire                 i_stall
);
    import bmbc_pkg::*;

    logic               r_out_valid;
    t_out_word          r_out;
    t_out_word          n_out;
    logic [LEVEL_W-1:0] r_last_sent;
    logic [LEVEL_W-1:0] n_last_sent;
    logic [READS_W-1:0] r_reads;
    logic [READS_W-1:0] n_reads;
    logic               r_boost_state;
    logic               n_boost_state;

    logic               fire;
    logic [MV_W-1:0]    mv;
    logic [MV_W-1:0]    lo_mv;
    logic [MV_W-1:0]    hi_mv;
    logic [MV_W-1:0]    ofs;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] diff;
    logic               send;

    assign o_ready = !r_out_valid || !i_stall;
    assign fire    = i_valid && o_ready;
    assign mv      = i_word.battery_mv;

    // level over the selected cell range
    always_comb begin
        lo_mv = i_cfg.li_ion_cell ? LION_LOW_MV  : COIN_LOW_MV;
        hi_mv = i_cfg.li_ion_cell ? LION_HIGH_MV : COIN_HIGH_MV;
        ofs   = mv - lo_mv;
        if (mv >= hi_mv) begin
            level = FULL_LEVEL;
        end else if (mv <= lo_mv) begin
            level = '0;
        end else begin
            level = ofs_div12(ofs[OFS_W-1:0]);
        end
        diff = (level > r_last_sent) ? level - r_last_sent : r_last_sent - level;
        send = (diff > i_cfg.change_threshold) || (r_reads == i_cfg.force_after_reads);
    end

    always_comb begin
        n_last_sent   = r_last_sent;
        n_reads       = r_reads;
        n_boost_state = r_boost_state;
        n_out.battery_mv    = mv;
        n_out.battery_level = level;
        n_out.send_level    = 1'b0;
        n_out.boost_write   = 1'b0;
        n_out.boost_on      = 1'b0;
        case (i_word.operation)
            OP_REPORT: begin
                if (i_cfg.battery_present) begin
                    if (send) begin
                        n_last_sent      = level;
                        n_reads          = '0;
                        n_out.send_level = 1'b1;
                    end else begin
                        n_reads = r_reads + READS_W'(1);
                    end
                end
            end
            OP_FORCE: begin
                n_reads = i_cfg.force_after_reads;
            end
            OP_ENTER, OP_EXIT: begin
                if (i_cfg.boost_present && !i_cfg.always_boost) begin
                    n_out.boost_write = 1'b1;
                    if (i_cfg.undervolt_boost) begin
                        if (!r_boost_state && (mv < BOOST_ENTER_MV)) begin
                            n_boost_state = 1'b1;
                        end else if (r_boost_state && (mv >= BOOST_LEAVE_MV)) begin
                            n_boost_state = 1'b0;
                        end
                        n_out.boost_on = n_boost_state;
                    end else begin
                        n_out.boost_on = (i_word.operation == OP_ENTER);
                    end
                end
            end
            default: begin
                n_reads = r_reads;
            end
        endcase
        n_out.low_voltage_mode = n_boost_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_last_sent   <= '0;
            r_reads       <= '0;
            r_boost_state <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (fire) begin
                r_last_sent   <= n_last_sent;
                r_reads       <= n_reads;
                r_boost_state <= n_boost_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
`default_nettype wire

### rtl/battery_monitor_boost_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_monitor_boost_control
// battery level reporting with change threshold and low-voltage boost control
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one event word (operation and
//   a 10-bit adc sample); a word is taken at a clock edge with valid high and
//   stall low
//   output channel: o_out_valid / i_out_stall carry one result word per event
//   (millivolts, percent level, send flag, boost write and level, hysteresis
//   state)
//   path: the result word passes the input register, millivolt register and
//   result register in turn after its event word is accepted
//   throughput: one word per clock when not stalled, set by three register
//   stages each holding one word; report state changes in the last stage only
//   stall: a stalled result word holds; words behind it keep moving until
//   all three stages are full, and only then is o_in_stall raised
//   reset: synchronous active low; empties the pipe, clears last sent level,
//   unsent read count and boost state, and loads the register defaults
//   config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high;
//   writes are expected only while the pipe is empty
// ----------------------------------------------------------------------------
module battery_monitor_boost_control (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  bmbc_pkg::t_in_word                    i_in_word,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output bmbc_pkg::t_out_word                   o_out_word,
    input  wire                                   i_cfg_we,
    input  wire  [bmbc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [bmbc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import bmbc_pkg::*;

    t_cfg     r_cfg;
    t_mv_word mv_word;
    logic     mv_valid;
    logic     mv_ready;
    logic     in_ready;

    // configuration registers, reset to their defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.li_ion_cell       <= 1'b0;
            r_cfg.change_threshold  <= LEVEL_W'(2);
            r_cfg.force_after_reads <= READS_W'(10);
            r_cfg.always_boost      <= 1'b0;
            r_cfg.undervolt_boost   <= 1'b0;
            r_cfg.boost_present     <= 1'b0;
            r_cfg.battery_present   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LI_ION_CELL:       r_cfg.li_ion_cell       <= i_cfg_data[0];
                CFG_CHANGE_THRESHOLD:  r_cfg.change_threshold  <= i_cfg_data[LEVEL_W-1:0];
                CFG_FORCE_AFTER_READS: r_cfg.force_after_reads <= i_cfg_data[READS_W-1:0];
                CFG_ALWAYS_BOOST:      r_cfg.always_boost      <= i_cfg_data[0];
                CFG_UNDERVOLT_BOOST:   r_cfg.undervolt_boost   <= i_cfg_data[0];
                CFG_BOOST_PRESENT:     r_cfg.boost_present     <= i_cfg_data[0];
                CFG_BATTERY_PRESENT:   r_cfg.battery_present   <= i_cfg_data[0];
                default: begin
                    // unused index, write dropped
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // stage 1 and 2: capture the event, convert the sample to millivolts
    bmbc_sample_stage u_sample (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_ready (in_ready),
        .o_valid (mv_valid),
        .o_word  (mv_word),
        .i_ready (mv_ready)
    );

    // stage 3: level, report and boost decisions, result register
    bmbc_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (mv_valid),
        .i_word  (mv_word),
        .o_ready (mv_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

    // stall only when every stage holds a word
    assign o_in_stall = !in_ready;

endmodule
`default_nettype wire

### rtl/bmbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmbc_checker
// port level checks for the battery monitor block
// ----------------------------------------------------------------------------
module bmbc_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 o_in_stall,
    input  wire                 o_out_valid,
    input  wire                 i_out_stall,
    input  bmbc_pkg::t_out_word o_out_word
);
    import bmbc_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // input stalls only when the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back pressure");

    // boost level is low unless the boost output is written
    a_boost_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.boost_write |-> !o_out_word.boost_on)
        else $error("boost level high without a boost write");

    // level never exceeds full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.battery_level <= FULL_LEVEL)
        else $error("battery level above full scale");

endmodule

bind battery_monitor_boost_control bmbc_checker u_bmbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire
